@@ rtl/point_in_polygon_test_core_defines.svh @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_defines
// assertion macros for the point in polygon test core
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pip assertion failed");
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pip assertion failed");
`else
`define PIP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// shared constants and types of the point in polygon test core
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;

    localparam int INDEX_W      = 4;
    localparam int VCOUNT_W     = 5;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(3);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_vertex;

    typedef struct packed {
        logic    valid;
        t_vertex vj;
        t_vertex vi;
    } t_edge_req;

    typedef struct packed {
        logic busy;
        logic parity;
    } t_eval_status;

endpackage

@@ rtl/pip_vertex_mem.sv @@
// ----------------------------------------------------------------------------
// pip_vertex_mem
// vertex store, one write port and one registered read port
// ----------------------------------------------------------------------------
module pip_vertex_mem (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [pip_pkg::ADDR_W-1:0] i_wr_addr,
    input  pip_pkg::t_vertex       i_wr_data,
    input  logic                   i_rd_en,
    input  logic [pip_pkg::ADDR_W-1:0] i_rd_addr,
    output pip_pkg::t_vertex       o_rd_data
);
    import pip_pkg::*;

    t_vertex r_mem [MAX_VERTICES];
    t_vertex r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/pip_edge_eval.sv @@
// ----------------------------------------------------------------------------
// pip_edge_eval
// crossing test of one edge per cycle, three stages, parity accumulator
// ----------------------------------------------------------------------------
module pip_edge_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  pip_pkg::t_edge_req                  i_req,
    input  logic signed [pip_pkg::COORD_BITS-1:0] i_px,
    input  logic signed [pip_pkg::COORD_BITS-1:0] i_py,
    output pip_pkg::t_eval_status               o_status
);
    import pip_pkg::*;

    logic                     r_s1_valid;
    logic                     r_s1_strad;
    logic                     r_s1_dpos;
    logic signed [DIFF_W-1:0] r_s1_a;
    logic signed [DIFF_W-1:0] r_s1_dy;
    logic signed [DIFF_W-1:0] r_s1_b;
    logic signed [DIFF_W-1:0] r_s1_c;

    logic                     r_s2_valid;
    logic                     r_s2_strad;
    logic                     r_s2_dpos;
    logic signed [PROD_W-1:0] r_s2_pl;
    logic signed [PROD_W-1:0] r_s2_pr;

    logic                     r_parity;

    logic signed [DIFF_W-1:0] n_dy;
    logic                     n_strad;
    logic                     n_left;

    // edge differences
    always_comb begin
        n_dy    = $signed({i_req.vj.y[COORD_BITS-1], i_req.vj.y})
                - $signed({i_req.vi.y[COORD_BITS-1], i_req.vi.y});
        n_strad = (i_req.vi.y > i_py) != (i_req.vj.y > i_py);
    end

    always_ff @(posedge i_clk) begin
        r_s1_dpos <= (n_dy > 0);
        r_s1_strad <= n_strad;
        r_s1_dy   <= n_dy;
        r_s1_a    <= $signed({i_px[COORD_BITS-1], i_px})
                   - $signed({i_req.vi.x[COORD_BITS-1], i_req.vi.x});
        r_s1_b    <= $signed({i_req.vj.x[COORD_BITS-1], i_req.vj.x})
                   - $signed({i_req.vi.x[COORD_BITS-1], i_req.vi.x});
        r_s1_c    <= $signed({i_py[COORD_BITS-1], i_py})
                   - $signed({i_req.vi.y[COORD_BITS-1], i_req.vi.y});
    end

    // cross products
    always_ff @(posedge i_clk) begin
        r_s2_strad <= r_s1_strad;
        r_s2_dpos  <= r_s1_dpos;
        r_s2_pl    <= PROD_W'(r_s1_a) * PROD_W'(r_s1_dy);
        r_s2_pr    <= PROD_W'(r_s1_b) * PROD_W'(r_s1_c);
    end

    assign n_left = r_s2_dpos ? (r_s2_pl < r_s2_pr) : (r_s2_pr < r_s2_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_parity   <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            if (i_clear) begin
                r_parity <= 1'b0;
            end else if (r_s2_valid && r_s2_strad && n_left) begin
                r_parity <= ~r_parity;
            end
        end
    end

    assign o_status.busy   = r_s1_valid | r_s2_valid;
    assign o_status.parity = r_parity;

endmodule

@@ rtl/point_in_polygon_test_core.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// crossing number point in polygon test over a stored vertex list
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_mode i_vertex_index i_x_coord i_y_coord
// output    out        o_out_valid / i_out_stall o_inside_res
// config    in         psel penable pwrite       paddr pwdata prdata
//
// a load writes the vertex store
// a query over n vertices walks the store, drains the edge evaluator and then shows
// its result, after which input is taken again; a count of zero skips the walk
// the walk makes one vertex store read per cycle and is followed by the evaluator drain
// reset is synchronous, active low; the vertex store is not cleared
// input stalls while a query walks, drains or waits for the output register
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_core_defines.svh"

module point_in_polygon_test_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_mode,
    input  logic [pip_pkg::INDEX_W-1:0]            i_vertex_index,
    input  logic signed [pip_pkg::COORD_BITS-1:0]  i_x_coord,
    input  logic signed [pip_pkg::COORD_BITS-1:0]  i_y_coord,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_inside_res,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pip_pkg::PADDR_W-1:0]            paddr,
    input  logic [pip_pkg::PDATA_W-1:0]            pwdata,
    output logic [pip_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);
    import pip_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_step, n_step;
    logic [CNT_W-1:0]        r_n, n_n;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic                    r_rd_valid, n_rd_valid;
    logic                    r_rd_first, n_rd_first;
    t_vertex                 r_prev;
    logic                    r_out_valid, n_out_valid;
    logic                    r_inside_res;
    logic [VCOUNT_W-1:0]     r_vertex_count;

    logic                    in_accept;
    logic                    query_accept;
    logic                    load_en;
    logic                    finish_now;
    logic [CNT_W-1:0]        rd_index;
    t_vertex                 wr_data;
    t_vertex                 rd_data;
    t_edge_req               edge_req;
    t_eval_status            eval_status;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign query_accept = in_accept && (i_mode == MODE_QUERY);
    assign load_en      = in_accept && (i_mode == MODE_LOAD)
                       && (32'(i_vertex_index) < 32'(MAX_VERTICES));
    assign o_in_stall   = (r_state != S_IDLE);
    assign finish_now   = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    assign wr_data.x = i_x_coord;
    assign wr_data.y = i_y_coord;

    // saturate the count to the store depth
    always_comb begin
        if (32'(r_vertex_count) > 32'(MAX_VERTICES)) begin
            n_n = CNT_W'(MAX_VERTICES);
        end else begin
            n_n = CNT_W'(r_vertex_count);
        end
    end

    // closing vertex first, then vertices in order
    assign rd_index = (r_step == '0) ? (r_n - CNT_W'(1)) : (r_step - CNT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rd_valid  = 1'b0;
        n_rd_first  = 1'b0;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (query_accept) begin
                    n_step  = '0;
                    n_state = (n_n == '0) ? S_DRAIN : S_WALK;
                end
            end
            S_WALK: begin
                n_rd_valid = 1'b1;
                n_rd_first = (r_step == '0);
                n_step     = r_step + CNT_W'(1);
                if (r_step == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_valid && !eval_status.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (finish_now) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= '0;
            r_rd_valid     <= 1'b0;
            r_rd_first     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_vertex_count <= VCOUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_rd_valid  <= n_rd_valid;
            r_rd_first  <= n_rd_first;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT)) begin
                r_vertex_count <= pwdata[VCOUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_accept) begin
            r_n  <= n_n;
            r_qx <= i_x_coord;
            r_qy <= i_y_coord;
        end
        if (r_rd_valid) begin
            r_prev <= rd_data;
        end
        if (finish_now) begin
            r_inside_res <= eval_status.parity;
        end
    end

    pip_vertex_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (load_en),
        .i_wr_addr (ADDR_W'(i_vertex_index)),
        .i_wr_data (wr_data),
        .i_rd_en   (r_state == S_WALK),
        .i_rd_addr (rd_index[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign edge_req.valid = r_rd_valid && !r_rd_first;
    assign edge_req.vj    = r_prev;
    assign edge_req.vi    = rd_data;

    pip_edge_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (query_accept),
        .i_req    (edge_req),
        .i_px     (r_qx),
        .i_py     (r_qy),
        .o_status (eval_status)
    );

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? PDATA_W'(r_vertex_count) : '0;

    `PIP_ASSERT_IMPL(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE,
        !r_rd_valid && !eval_status.busy)
    `PIP_ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, r_state == S_WALK, r_step <= r_n)
    `PIP_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, finish_now, o_out_valid)

endmodule

@@ tb/point_in_polygon_test_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_tb
// self-checking testbench for the crossing number point in polygon core
//
// loads polygons into the vertex store and queries points against them under
// several vertex counts written over the config port, with random idling and
// stalling on both channels. every query is predicted from a local copy of
// the vertex store using exact integer crossing tests, and each result
// transaction is compared against the oldest pending prediction.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_tb;
    import pip_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 115;
    localparam logic [PADDR_W-1:0] VCOUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};

    typedef logic signed [COORD_BITS-1:0] t_coord;

    class inside_scoreboard;
        t_coord              vert_x [MAX_VERTICES];
        t_coord              vert_y [MAX_VERTICES];
        logic [VCOUNT_W-1:0] vertex_count;
        bit                  expected_inside [$];
        int                  errors;

        function new();
            vertex_count = VCOUNT_RESET;
            errors = 0;
        endfunction

        function void set_vertex_count(logic [VCOUNT_W-1:0] value);
            vertex_count = value;
        endfunction

        function bit crossing_parity(t_coord px, t_coord py);
            int     n;
            int     i;
            int     j;
            longint qx;
            longint qy;
            longint xi;
            longint yi;
            longint xj;
            longint yj;
            longint dy;
            longint lhs;
            longint rhs;
            bit     parity;
            bit     left;
            parity = 0;
            qx = px;
            qy = py;
            n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
            j = (n == 0) ? 0 : n - 1;
            for (i = 0; i < n; i++) begin
                xi = vert_x[i];
                yi = vert_y[i];
                xj = vert_x[j];
                yj = vert_y[j];
                if ((yi > qy) != (yj > qy)) begin
                    dy = yj - yi;
                    lhs = (qx - xi) * dy;
                    rhs = (xj - xi) * (qy - yi);
                    left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                    if (left) begin
                        parity = ~parity;
                    end
                end
                j = i;
            end
            return parity;
        endfunction

        function void note_input(logic mode, logic [INDEX_W-1:0] slot, t_coord x, t_coord y);
            if (mode == MODE_LOAD) begin
                if (slot < MAX_VERTICES) begin
                    vert_x[slot] = x;
                    vert_y[slot] = y;
                end
            end else begin
                expected_inside = {expected_inside, crossing_parity(x, y)};
            end
        endfunction

        function void check_result(logic actual);
            bit want;
            if (expected_inside.size() == 0) begin
                $error("inside_res: no query pending, actual %0b", actual);
                errors++;
                return;
            end
            want = expected_inside.pop_front();
            if (actual !== want) begin
                $error("inside_res: expected %0b, actual %0b", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_inside.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_mode;
    logic [INDEX_W-1:0]  i_vertex_index;
    t_coord              i_x_coord;
    t_coord              i_y_coord;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_inside_res;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    inside_scoreboard sb = new();
    int  cycle_count = 0;
    int  idle_pct = 0;
    bit  quiet = 0;
    bit  hold_req = 0;
    int  span;
    int  cx;
    int  cy;

    point_in_polygon_test_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_vertex_index (i_vertex_index),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_inside_res);
        end
    end

    // result side stalling
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(input logic mode, input logic [INDEX_W-1:0] slot,
                             input t_coord x, input t_coord y);
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_mode         = mode;
        i_vertex_index = slot;
        i_x_coord      = x;
        i_y_coord      = y;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(mode, slot, x, y);
    endtask

    task automatic send_query(input t_coord x, input t_coord y);
        send_item(MODE_QUERY, INDEX_W'($urandom), x, y);
    endtask

    task automatic idle(input int len);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (len - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            idle($urandom_range(1, 16));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_count(input int count);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(VCOUNT_ADDR, PDATA_W'(count));
        sb.set_vertex_count(VCOUNT_W'(count));
    endtask

    function automatic t_coord clamp_coord(int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return t_coord'(v);
    endfunction

    function automatic t_coord any_coord();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_coord box_coord(int center);
        return clamp_coord(center + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_item(input int n);
        int     r;
        t_coord x;
        t_coord y;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send_item(MODE_LOAD, INDEX_W'($urandom), box_coord(cx), box_coord(cy));
        end else if (r < 15) begin
            send_item(MODE_LOAD, INDEX_W'($urandom), any_coord(), any_coord());
        end else begin
            x = box_coord(cx);
            y = box_coord(cy);
            r = $urandom_range(0, 9);
            if (r == 0) begin
                x = any_coord();
                y = any_coord();
            end else if (r <= 3 && n > 0) begin
                y = sb.vert_y[$urandom_range(0, n - 1)];
            end else if (r == 4 && n > 0) begin
                x = sb.vert_x[$urandom_range(0, n - 1)];
            end
            send_query(x, y);
        end
    endtask

    initial begin
        int count_plan [NUM_PHASES];
        int p;
        int k;
        int n;
        int count;

        count_plan     = '{16, 0, 1, 2, 31, 17, 3, 16, -1, -1, -1, -1};
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_LOAD;
        i_vertex_index = '0;
        i_x_coord      = '0;
        i_y_coord      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: fill every slot, corners of the full square first
        send_item(MODE_LOAD, 4'd0, 16'sh8000, 16'sh8000);
        send_item(MODE_LOAD, 4'd1, 16'sh7fff, 16'sh8000);
        send_item(MODE_LOAD, 4'd2, 16'sh7fff, 16'sh7fff);
        send_item(MODE_LOAD, 4'd3, 16'sh8000, 16'sh7fff);
        for (k = 4; k < MAX_VERTICES; k++) begin
            send_item(MODE_LOAD, INDEX_W'(k), t_coord'(1000 * k), t_coord'(-1000 * k));
        end
        // triangle at reset count, including horizontal edge and vertex hits
        send_query(16'sd30000, -16'sd30000);
        send_query(-16'sd30000, 16'sd30000);
        send_query(16'sd0, 16'sh8000);
        send_query(16'sh7fff, 16'sd0);
        send_query(16'sh8000, 16'sh8000);
        send_query(16'sd0, 16'sd0);
        set_count(4);
        send_query(16'sd0, 16'sd0);
        send_query(16'sh8000, 16'sd0);
        send_query(16'sd100, 16'sh7fff);

        for (p = 0; p < NUM_PHASES; p++) begin
            count = (count_plan[p] < 0) ? int'($urandom_range(3, 16)) : count_plan[p];
            set_count(count);
            n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
            quiet = (p == NUM_PHASES - 1);
            idle_pct = (p % 4 == 1) ? 0 : int'($urandom_range(10, 40));
            case ($urandom_range(0, 3))
                0: span = 8;
                1: span = 300;
                2: span = 5000;
                default: span = 32768;
            endcase
            cx = (span == 32768) ? 0 : int'($urandom_range(0, 65535)) - 32768;
            cy = (span == 32768) ? 0 : int'($urandom_range(0, 65535)) - 32768;
            for (k = 0; k < n; k++) begin
                maybe_idle();
                send_item(MODE_LOAD, INDEX_W'(k), box_coord(cx), box_coord(cy));
            end
            for (k = 0; k < PHASE_ITEMS - n; k++) begin
                if (p == 2 && k == 20) begin
                    hold_req = 1;
                end
                if (p == 5 && k == 30) begin
                    wait_drained();
                end
                maybe_idle();
                random_item(n);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
